FILE: design/ship_pkg.sv
// Package for the signature-based SRRIP replacement engine.
// Shared sizes, item and metadata types and the sequencer state type.
// No dependencies.
package ship_pkg;

  // Geometry and field widths
  localparam int NUM_SETS      = 2048;
  localparam int NUM_WAYS      = 16;
  localparam int RRPV_WIDTH    = 2;
  localparam int SIG_WIDTH     = 14;
  localparam int COUNTER_WIDTH = 3;

  localparam int SET_W       = $clog2(NUM_SETS);
  localparam int WAY_W       = $clog2(NUM_WAYS);
  localparam int SIG_ENTRIES = 1 << SIG_WIDTH;

  localparam logic [RRPV_WIDTH-1:0]    RV_MAX     = '1;
  localparam logic [COUNTER_WIDTH-1:0] CTR_MAX    = '1;
  localparam logic [COUNTER_WIDTH-1:0] CTR_THRESH = (CTR_MAX >> 1) + 1'b1;

  // Clearing pass covers the larger of the two stores
  localparam int CLR_ENTRIES = (SIG_ENTRIES > NUM_SETS) ? SIG_ENTRIES : NUM_SETS;
  localparam int CLR_W       = $clog2(CLR_ENTRIES);

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    OP_VICTIM = 1'b0,
    OP_UPDATE = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e              op;
    logic [SET_W-1:0]     set;
    logic [WAY_W-1:0]     way;
    logic                 hit;
    logic [SIG_WIDTH-1:0] sig;
  } item_t;

  typedef struct packed {
    logic                  valid;
    logic                  refd;
    logic [SIG_WIDTH-1:0]  sig;
    logic [RRPV_WIDTH-1:0] rrpv;
  } way_meta_t;

  typedef way_meta_t [NUM_WAYS-1:0] row_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_VPICK,
    S_TRAIN,
    S_INSERT
  } state_e;

endpackage

FILE: design/ship_front.sv
// Front end: takes command items, derives set and signature, drops updates
// to ways that do not exist, and queues the rest for the back end.
// Depends on ship_pkg.
module ship_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic            opcode_i,
  input  logic [10:0]     set_index_i,
  input  logic [3:0]      way_i,
  input  logic            hit_i,
  input  logic [63:0]     pc_i,
  input  logic            clearing_i,
  input  logic            pop_i,
  output logic            item_valid_o,
  output ship_pkg::item_t item_o
);
  import ship_pkg::*;

  item_t             fifo_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              full, accept, push, pop;
  item_t             item_in;

  // Classify the incoming item
  always_comb begin
    item_in     = '0;
    item_in.op  = opcode_e'(opcode_i);
    item_in.set = set_index_i[SET_W-1:0];
    item_in.way = way_i[WAY_W-1:0];
    item_in.hit = hit_i;
    item_in.sig = pc_i[SIG_WIDTH+1:2];
  end

  assign full   = (cnt_q == QCNT_W'(QDEPTH));
  assign busy   = full | clearing_i;
  assign accept = start & ~busy;
  assign push   = accept & ((opcode_e'(opcode_i) == OP_VICTIM) || (int'(way_i) < NUM_WAYS));
  assign pop    = pop_i & item_valid_o;

  assign item_valid_o = (cnt_q != '0);
  assign item_o       = fifo_q[rd_ptr_q];

  // Queue pointers
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (int'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (int'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

FILE: design/ship_back.sv
// Back end: per-set metadata memory, signature counter table and the
// sequencer that runs victim searches, hit promotion and fill training.
// Depends on ship_pkg.
module ship_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  input  ship_pkg::item_t             item_i,
  output logic                        pop_o,
  output logic                        clearing_o,
  output logic                        victim_valid_o,
  output logic [ship_pkg::WAY_W-1:0]  victim_way_o
);
  import ship_pkg::*;

  row_t                     row_mem [NUM_SETS];
  logic [COUNTER_WIDTH-1:0] ctr_mem [SIG_ENTRIES];

  state_e                   state_q, state_d;
  item_t                    cur_q, cur_d;
  logic [RRPV_WIDTH-1:0]    maxv_q, maxv_d;
  logic [COUNTER_WIDTH-1:0] trn_q, trn_d;
  logic                     byp_q, byp_d;
  logic [CLR_W-1:0]         clr_q, clr_d;
  logic                     vval_q, vval_d;
  logic [WAY_W-1:0]         vway_q, vway_d;

  row_t                     row_rd_q;
  logic [COUNTER_WIDTH-1:0] ctr_rd_q;

  logic                     row_re, row_we, ctr_re, ctr_we;
  logic [SET_W-1:0]         row_raddr, row_waddr;
  row_t                     row_wdata;
  logic [SIG_WIDTH-1:0]     ctr_raddr, ctr_waddr;
  logic [COUNTER_WIDTH-1:0] ctr_wdata;

  logic [RV_MAX:0]          present;
  logic [RRPV_WIDTH-1:0]    row_max;
  logic [RRPV_WIDTH-1:0]    delta;
  logic [WAY_W-1:0]         first_way;
  logic                     found;
  way_meta_t                old_meta;
  logic [COUNTER_WIDTH-1:0] trained, ins_ctr;
  row_t                     row_mod;

  // Highest re-reference value present in the set just read
  always_comb begin
    present = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      present[row_rd_q[w].rrpv] = 1'b1;
    end
    row_max = '0;
    for (int v = 0; v <= int'(RV_MAX); v++) begin
      if (present[v]) begin
        row_max = RRPV_WIDTH'(v);
      end
    end
  end

  // Lowest way at the set maximum; aging step that lifts it to the top
  always_comb begin
    delta     = RV_MAX - maxv_q;
    first_way = '0;
    found     = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!found && (row_rd_q[w].rrpv == maxv_q)) begin
        first_way = WAY_W'(w);
        found     = 1'b1;
      end
    end
  end

  // Saturating training of the evicted block's counter
  always_comb begin
    old_meta = row_rd_q[cur_q.way];
    trained  = ctr_rd_q;
    if (old_meta.refd) begin
      if (ctr_rd_q < CTR_MAX) trained = ctr_rd_q + 1'b1;
    end else begin
      if (ctr_rd_q != '0) trained = ctr_rd_q - 1'b1;
    end
    ins_ctr = byp_q ? trn_q : ctr_rd_q;
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    maxv_d    = maxv_q;
    trn_d     = trn_q;
    byp_d     = byp_q;
    clr_d     = clr_q;
    vval_d    = 1'b0;
    vway_d    = vway_q;
    pop_o     = 1'b0;
    row_re    = 1'b0;
    row_raddr = item_i.set;
    row_we    = 1'b0;
    row_waddr = cur_q.set;
    row_wdata = row_rd_q;
    ctr_re    = 1'b0;
    ctr_raddr = old_meta.sig;
    ctr_we    = 1'b0;
    ctr_waddr = old_meta.sig;
    ctr_wdata = trained;
    row_mod   = row_rd_q;

    unique case (state_q)
      S_CLEAR: begin
        row_waddr = clr_q[SET_W-1:0];
        row_we    = (int'(clr_q) < NUM_SETS);
        for (int w = 0; w < NUM_WAYS; w++) begin
          row_wdata[w]      = '0;
          row_wdata[w].rrpv = RV_MAX;
        end
        ctr_waddr = clr_q[SIG_WIDTH-1:0];
        ctr_we    = (int'(clr_q) < SIG_ENTRIES);
        ctr_wdata = CTR_THRESH;
        clr_d     = clr_q + 1'b1;
        if (int'(clr_q) == CLR_ENTRIES - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid_i) begin
          pop_o   = 1'b1;
          row_re  = 1'b1;
          cur_d   = item_i;
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (cur_q.op == OP_VICTIM) begin
          maxv_d  = row_max;
          state_d = S_VPICK;
        end else if (cur_q.hit) begin
          row_mod[cur_q.way].rrpv = '0;
          row_mod[cur_q.way].refd = 1'b1;
          row_wdata = row_mod;
          row_we    = 1'b1;
          state_d   = S_IDLE;
        end else begin
          ctr_re    = 1'b1;
          ctr_raddr = old_meta.sig;
          state_d   = S_TRAIN;
        end
      end
      S_VPICK: begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          row_mod[w].rrpv = row_rd_q[w].rrpv + delta;
        end
        row_wdata = row_mod;
        row_we    = 1'b1;
        vval_d    = 1'b1;
        vway_d    = first_way;
        state_d   = S_IDLE;
      end
      S_TRAIN: begin
        // write back the trained counter and fetch the new block's one
        ctr_we    = old_meta.valid;
        ctr_waddr = old_meta.sig;
        ctr_wdata = trained;
        ctr_re    = 1'b1;
        ctr_raddr = cur_q.sig;
        trn_d     = trained;
        byp_d     = old_meta.valid && (old_meta.sig == cur_q.sig);
        state_d   = S_INSERT;
      end
      S_INSERT: begin
        row_mod[cur_q.way].rrpv  = (ins_ctr >= CTR_THRESH) ? '0 : RV_MAX;
        row_mod[cur_q.way].sig   = cur_q.sig;
        row_mod[cur_q.way].refd  = 1'b0;
        row_mod[cur_q.way].valid = 1'b1;
        row_wdata = row_mod;
        row_we    = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      vval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      vval_q  <= vval_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    maxv_q <= maxv_d;
    trn_q  <= trn_d;
    byp_q  <= byp_d;
    vway_q <= vway_d;
  end

  // Set metadata memory
  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    if (row_re) begin
      row_rd_q <= row_mem[row_raddr];
    end
  end

  // Signature counter memory
  always_ff @(posedge clk_i) begin
    if (ctr_we) begin
      ctr_mem[ctr_waddr] <= ctr_wdata;
    end
    if (ctr_re) begin
      ctr_rd_q <= ctr_mem[ctr_raddr];
    end
  end

  assign clearing_o     = (state_q == S_CLEAR);
  assign victim_valid_o = vval_q;
  assign victim_way_o   = vway_q;

endmodule

FILE: design/ship_srrip_replacement.sv
// Top level of the signature-based SRRIP replacement engine.
// Instantiates ship_front and ship_back; depends on ship_pkg.
//
// After reset the engine sweeps its set metadata and counter stores, one
// entry a cycle, with busy high throughout. Items are taken when start is
// high and busy low; a two-entry queue holds them until the sequencer is
// free. A victim request runs the sequencer through S_IDLE, S_READ and
// S_VPICK, and victim_way_o is shown for one cycle under victim_valid_o in
// the cycle after S_VPICK. A hit update runs S_IDLE and S_READ, and a fill
// S_IDLE, S_READ, S_TRAIN and S_INSERT, a read-modify-write of the set row
// and of the counter table. Results cannot be held off, so victim_way_o
// must be captured in the cycle that victim_valid_o is high.
module ship_srrip_replacement (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [10:0] set_index_i,
  input  logic [3:0]  way_i,
  input  logic        hit_i,
  input  logic [63:0] pc_i,
  output logic        victim_valid_o,
  output logic [3:0]  victim_way_o
);
  import ship_pkg::*;

  item_t            item;
  logic             item_valid, pop, clearing;
  logic [WAY_W-1:0] vway;

  // Command intake and queue
  ship_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .set_index_i  (set_index_i),
    .way_i        (way_i),
    .hit_i        (hit_i),
    .pc_i         (pc_i),
    .clearing_i   (clearing),
    .pop_i        (pop),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // Replacement state and sequencer
  ship_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .item_i         (item),
    .pop_o          (pop),
    .clearing_o     (clearing),
    .victim_valid_o (victim_valid_o),
    .victim_way_o   (vway)
  );

  assign victim_way_o = 4'(vway);

endmodule

FILE: sim/tb_ship_srrip_replacement.sv
// Testbench for the signature-based SRRIP replacement engine.
// Drives victim requests and updates, predicts victim ways; depends on ship_pkg.
`timescale 1ns / 1ps

module tb_ship_srrip_replacement;
  import ship_pkg::*;

  // Prediction state and the queue of victim ways still to come
  class victim_scoreboard;
    logic [RRPV_WIDTH-1:0]    rrpv [NUM_SETS][NUM_WAYS];
    logic [SIG_WIDTH-1:0]     bsig [NUM_SETS][NUM_WAYS];
    bit                       refd [NUM_SETS][NUM_WAYS];
    bit                       vld  [NUM_SETS][NUM_WAYS];
    logic [COUNTER_WIDTH-1:0] ctr  [SIG_ENTRIES];
    logic [3:0]               pending_ways [$];
    int                       errors;
    int                       victims_seen;

    function new();
      for (int s = 0; s < NUM_SETS; s++)
        for (int w = 0; w < NUM_WAYS; w++) begin
          rrpv[s][w] = RV_MAX;
          bsig[s][w] = '0;
          refd[s][w] = 0;
          vld[s][w]  = 0;
        end
      for (int i = 0; i < SIG_ENTRIES; i++) ctr[i] = CTR_THRESH;
      errors = 0;
      victims_seen = 0;
    endfunction

    // Note an accepted item and update the predicted state
    function void note_item(bit op, logic [10:0] set_idx, logic [3:0] w, bit h,
                            logic [63:0] pc);
      int s;
      logic [SIG_WIDTH-1:0] sg, old;
      bit found;
      logic [3:0] vw;
      s = set_idx % NUM_SETS;
      sg = pc[SIG_WIDTH+1:2];
      found = 0;
      vw = '0;
      if (opcode_e'(op) == OP_VICTIM) begin
        for (int r = 0; r <= RV_MAX && !found; r++) begin
          for (int k = 0; k < NUM_WAYS && !found; k++)
            if (rrpv[s][k] == RV_MAX) begin
              found = 1;
              vw = 4'(k);
            end
          if (!found)
            for (int k = 0; k < NUM_WAYS; k++)
              if (rrpv[s][k] < RV_MAX) rrpv[s][k]++;
        end
        pending_ways.push_back(vw);
      end else if (w < NUM_WAYS) begin
        if (h) begin
          rrpv[s][w] = '0;
          refd[s][w] = 1;
        end else begin
          // train the counter of the evicted block
          if (vld[s][w]) begin
            old = bsig[s][w];
            if (refd[s][w]) begin
              if (ctr[old] < CTR_MAX) ctr[old]++;
            end else if (ctr[old] > 0) begin
              ctr[old]--;
            end
          end
          rrpv[s][w] = (ctr[sg] >= CTR_THRESH) ? '0 : RV_MAX;
          bsig[s][w] = sg;
          refd[s][w] = 0;
          vld[s][w]  = 1;
        end
      end
    endfunction

    // Compare one victim result with the oldest expectation
    function void check_victim(logic [3:0] got);
      logic [3:0] exp_way;
      victims_seen++;
      if (pending_ways.size() == 0) begin
        $display("%0t: unexpected victim_way %0d", $time, got);
        errors++;
      end else begin
        exp_way = pending_ways.pop_front();
        if (got !== exp_way) begin
          $display("%0t: victim_way expected %0d actual %0d", $time, exp_way, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic        opcode = 0;
  logic [10:0] set_index = '0;
  logic [3:0]  way = '0;
  logic        hit = 0;
  logic [63:0] pc = '0;
  logic        victim_valid;
  logic [3:0]  victim_way;

  victim_scoreboard sb;
  int items_sent;
  int fills_sent;

  always #5 clk = ~clk;

  ship_srrip_replacement dut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy),
    .opcode_i(opcode), .set_index_i(set_index), .way_i(way), .hit_i(hit),
    .pc_i(pc), .victim_valid_o(victim_valid), .victim_way_o(victim_way)
  );

  // Results cannot be held off: check at every strobe
  always @(posedge clk) begin
    if (rst_n && victim_valid) sb.check_victim(victim_way);
  end

  // Present one item and hold it until accepted
  task automatic send_item(bit op, logic [10:0] s, logic [3:0] w, bit h,
                           logic [63:0] p);
    start     <= 1;
    opcode    <= op;
    set_index <= s;
    way       <= w;
    hit       <= h;
    pc        <= p;
    do @(posedge clk); while (busy);
    sb.note_item(op, s, w, h, p);
    items_sent++;
    if (op && !h) fills_sent++;
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      start <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Few sets and a handful of signatures so that sets fill and counters train
  function automatic logic [63:0] rand_pc(bit wide);
    logic [63:0] p;
    p = {$urandom, $urandom};
    if (!wide) p[15:2] = 14'($urandom_range(0, 7));
    return p;
  endfunction

  task automatic send_random(bit busy_mode);
    int r;
    logic [10:0] s;
    r = $urandom_range(0, 99);
    s = busy_mode ? 11'($urandom_range(0, 3)) : 11'($urandom);
    if (r < 40)
      send_item(0, s, 4'($urandom), 1'($urandom), rand_pc(1));
    else if (r < 65)
      send_item(1, s, 4'($urandom), 1, rand_pc(r < 45));
    else
      send_item(1, s, 4'($urandom), 0, rand_pc(r < 70));
  endtask

  initial begin
    sb = new();
    items_sent = 0;
    fills_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: victims on fresh sets, extremes of set and pc
    send_item(0, 11'd0, 4'd0, 0, 64'd0);
    send_item(0, 11'h7FF, 4'hF, 1, '1);
    // fill into invalid ways, then hit and fill again to train up
    send_item(1, 11'd5, 4'd0, 0, 64'h0000_0000_0000_0004);
    send_item(1, 11'd5, 4'd15, 0, '1);
    send_item(0, 11'd5, 4'd0, 0, 64'd0);
    send_item(1, 11'd5, 4'd0, 1, 64'h1234);
    send_item(1, 11'd5, 4'd0, 0, 64'h8);
    // unreferenced eviction trains down; repeat to saturate at zero
    for (int i = 0; i < 6; i++) send_item(1, 11'd6, 4'd3, 0, 64'h10);
    // referenced evictions until the counter saturates at maximum
    for (int i = 0; i < 5; i++) begin
      send_item(1, 11'd7, 4'd2, 0, 64'h20);
      send_item(1, 11'd7, 4'd2, 1, 64'h0);
    end
    // only way 2 promoted: victims find way 0 still at the maximum
    send_item(0, 11'd7, 4'd0, 0, 64'd0);
    send_item(0, 11'd7, 4'd0, 0, 64'd0);

    // Hold off until every victim has come
    start <= 0;
    while (sb.pending_ways.size() != 0) @(posedge clk);

    // Random bursts with gaps; stretches without gaps
    while (items_sent < 1140) begin
      int burst;
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst; i++) send_random(items_sent % 400 < 300);
      if (items_sent % 300 > 150) idle_cycles(0);
      else idle_cycles($urandom_range(0, 7));
    end
    start <= 0;

    while (sb.pending_ways.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d items (%0d fills); %0d victim results checked.",
             items_sent, fills_sent, sb.victims_seen);
    if (sb.errors == 0 && sb.pending_ways.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Timeout covering the clearing pass plus about 1200 items
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
design/ship_pkg.sv
design/ship_front.sv
design/ship_back.sv
design/ship_srrip_replacement.sv
sim/tb_ship_srrip_replacement.sv
